// File: src/icl_pkg.sv
// Shared types and constants for the indexed character list engine.
// Used by icl_cell and indexed_char_list_engine_core; depends on nothing.
package icl_pkg;

    localparam int LIST_CAPACITY = 64;
    localparam int IDX_W         = (LIST_CAPACITY > 1) ? $clog2(LIST_CAPACITY) : 1;
    localparam int CNT_W         = $clog2(LIST_CAPACITY + 1);
    localparam int CHAR_W        = 8;
    localparam int REQ_W         = 4;
    localparam int POS_W         = 7;
    localparam int STAT_W        = 2;
    localparam int CNT_OUT_W     = 7;
    // Width wide enough to compare a position against the count.
    localparam int CMP_W         = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_BACK     = 4'd0,
        REQ_PUSH_FRONT    = 4'd1,
        REQ_INSERT_AT     = 4'd2,
        REQ_INSERT_SORTED = 4'd3,
        REQ_POP_FRONT     = 4'd4,
        REQ_POP_BACK      = 4'd5,
        REQ_REMOVE_AT     = 4'd6,
        REQ_REPLACE       = 4'd7,
        REQ_READ          = 4'd8,
        REQ_CLEAR         = 4'd9
    } t_req;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    // Per-cell update command.
    typedef struct packed {
        logic load;        // take the request's character
        logic from_left;   // take the lower neighbor's entry (opening a slot)
        logic from_right;  // take the upper neighbor's entry (closing a slot)
    } t_cell_ctl;

endpackage

// File: src/indexed_char_list_engine_core.sv
// Indexed character list engine: an ordered list of signed characters held in a row of cells.
// A request waits in the holding register; its result is then registered at the output.
// Takes one request per cycle unless the output stalls; cells shift, load or hold on execute.
// The sorted insert point comes from a log-depth prefix OR over the cells' compare bits.
// Reset (synchronous, active low) clears the count and handshake state; cell contents are
// left as they are and are only read below the count.
module indexed_char_list_engine_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_req_valid,
    output logic                        o_req_ready,
    input  logic [icl_pkg::REQ_W-1:0]   i_req_type,
    input  logic signed [icl_pkg::CHAR_W-1:0] i_char_value,
    input  logic [icl_pkg::POS_W-1:0]   i_position,
    output logic                        o_rsp_valid,
    input  logic                        i_rsp_ready,
    output logic [icl_pkg::STAT_W-1:0]  o_status,
    output logic signed [icl_pkg::CHAR_W-1:0] o_read_value,
    output logic [icl_pkg::CNT_OUT_W-1:0] o_item_count,
    output logic                        o_list_empty,
    output logic signed [icl_pkg::CHAR_W-1:0] o_first_value,
    output logic signed [icl_pkg::CHAR_W-1:0] o_last_value
);
    import icl_pkg::*;

    // Request holding register. A request waits here until the output register
    // can take its result; the next request may be accepted in that same cycle.
    logic               r_pend;
    logic [REQ_W-1:0]   r_req_type;
    logic [CHAR_W-1:0]  r_char;
    logic [POS_W-1:0]   r_pos;
    logic [CNT_W-1:0]   r_count;

    logic               r_out_valid;
    logic [STAT_W-1:0]  r_out_status;
    logic [CHAR_W-1:0]  r_out_read;
    logic [CNT_OUT_W-1:0] r_out_count;
    logic               r_out_empty;
    logic [CHAR_W-1:0]  r_out_first;
    logic [CHAR_W-1:0]  r_out_last;

    logic w_exec;
    logic w_accept;

    // Cell row wiring.
    logic [CHAR_W-1:0]        w_val  [LIST_CAPACITY];
    logic [CHAR_W-1:0]        w_nxt  [LIST_CAPACITY];
    t_cell_ctl                w_ctl  [LIST_CAPACITY];
    logic [LIST_CAPACITY-1:0] w_gt;

    // Decoded request.
    logic             w_ins;
    logic             w_rem;
    logic             w_rep;
    logic             w_rd;
    logic             w_sorted;
    logic [CMP_W-1:0] w_k;
    logic [STAT_W-1:0] w_status;
    logic [CNT_W-1:0] w_n_count;
    logic [CMP_W-1:0] w_pos_x;
    logic [CMP_W-1:0] w_count_x;
    logic             w_full;
    logic             w_empty;

    // Per-cell position flags.
    logic [LIST_CAPACITY-1:0] w_live;
    logic [LIST_CAPACITY-1:0] w_ge;
    logic [LIST_CAPACITY-1:0] w_eq;
    logic [LIST_CAPACITY-1:0] w_pre [IDX_W+1];
    logic [CHAR_W-1:0]        w_read_value;
    logic [CHAR_W-1:0]        w_last_value;

    // A request executes when the output register is free or is being emptied.
    assign w_exec      = r_pend && (!r_out_valid || i_rsp_ready);
    assign o_req_ready = !r_pend || w_exec;
    assign w_accept    = i_req_valid && o_req_ready;

    assign w_pos_x   = CMP_W'(r_pos);
    assign w_count_x = CMP_W'(r_count);
    assign w_full    = (r_count == CNT_W'(LIST_CAPACITY));
    assign w_empty   = (r_count == '0);

    // Request decode. Only a request that succeeds sets a cell action.
    always_comb begin
        w_ins     = 1'b0;
        w_rem     = 1'b0;
        w_rep     = 1'b0;
        w_rd      = 1'b0;
        w_sorted  = 1'b0;
        w_k       = '0;
        w_status  = ST_OK;
        w_n_count = r_count;
        unique case (r_req_type)
            REQ_PUSH_BACK, REQ_PUSH_FRONT, REQ_INSERT_SORTED: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_ins     = 1'b1;
                    w_sorted  = (r_req_type == REQ_INSERT_SORTED);
                    w_k       = (r_req_type == REQ_PUSH_BACK) ? w_count_x : '0;
                    w_n_count = r_count + CNT_W'(1);
                end
            end
            REQ_INSERT_AT: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else if (w_pos_x > w_count_x) begin
                    w_status = ST_RANGE;
                end else begin
                    w_ins     = 1'b1;
                    w_k       = w_pos_x;
                    w_n_count = r_count + CNT_W'(1);
                end
            end
            REQ_POP_FRONT, REQ_POP_BACK: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_rem     = (r_req_type == REQ_POP_FRONT);
                    w_n_count = r_count - CNT_W'(1);
                end
            end
            REQ_REMOVE_AT, REQ_REPLACE, REQ_READ: begin
                w_k = w_pos_x;
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else if (w_pos_x >= w_count_x) begin
                    w_status = ST_RANGE;
                end else begin
                    w_rem = (r_req_type == REQ_REMOVE_AT);
                    w_rep = (r_req_type == REQ_REPLACE);
                    w_rd  = (r_req_type == REQ_READ);
                    if (r_req_type == REQ_REMOVE_AT) begin
                        w_n_count = r_count - CNT_W'(1);
                    end
                end
            end
            REQ_CLEAR: begin
                w_n_count = '0;
            end
            default: begin
            end
        endcase
    end

    // Sorted insert: the slot opens at the first live cell greater than the new
    // character, found with a log-depth prefix OR. With no such cell it appends.
    always_comb begin
        for (int i = 0; i < LIST_CAPACITY; i++) begin
            w_live[i] = (CMP_W'(i) < w_count_x);
        end
        w_pre[0] = w_gt & w_live;
        for (int l = 0; l < IDX_W; l++) begin
            for (int i = 0; i < LIST_CAPACITY; i++) begin
                if (i >= (1 << l)) begin
                    w_pre[l+1][i] = w_pre[l][i] | w_pre[l][i - (1 << l)];
                end else begin
                    w_pre[l+1][i] = w_pre[l][i];
                end
            end
        end
    end

    // Cell commands: cells at or above the slot shift, the slot cell itself loads.
    always_comb begin
        for (int i = 0; i < LIST_CAPACITY; i++) begin
            w_ge[i] = w_sorted ? (w_pre[IDX_W][i] | ~w_live[i]) : (CMP_W'(i) >= w_k);
        end
        for (int i = 0; i < LIST_CAPACITY; i++) begin
            if (i == 0) begin
                w_eq[i] = w_ge[i];
            end else begin
                w_eq[i] = w_ge[i] & ~w_ge[i-1];
            end
            w_ctl[i].load       = w_exec & (w_ins | w_rep) & w_eq[i];
            w_ctl[i].from_left  = w_exec & w_ins & w_ge[i] & ~w_eq[i];
            w_ctl[i].from_right = w_exec & w_rem & w_ge[i];
        end
    end

    // Read selects the addressed cell before the update; the last entry is taken
    // from the cells' next values at the new count minus one.
    always_comb begin
        w_read_value = '0;
        w_last_value = '0;
        for (int i = 0; i < LIST_CAPACITY; i++) begin
            if (w_rd && w_eq[i]) begin
                w_read_value = w_read_value | w_val[i];
            end
            if (CNT_W'(i) + CNT_W'(1) == w_n_count) begin
                w_last_value = w_last_value | w_nxt[i];
            end
        end
    end

    for (genvar g = 0; g < LIST_CAPACITY; g++) begin : g_cell
        logic [CHAR_W-1:0] w_left;
        logic [CHAR_W-1:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = w_val[g];
        end else begin : g_mid_l
            assign w_left = w_val[g-1];
        end
        if (g == LIST_CAPACITY - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_val[g+1];
        end
        icl_cell u_cell (
            .i_clk         (i_clk),
            .i_ctl         (w_ctl[g]),
            .i_new_value   (r_char),
            .i_left_value  (w_left),
            .i_right_value (w_right),
            .o_value       (w_val[g]),
            .o_next_value  (w_nxt[g]),
            .o_greater     (w_gt[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_pend <= 1'b1;
            end else if (w_exec) begin
                r_pend <= 1'b0;
            end
            if (w_exec) begin
                r_count     <= w_n_count;
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req_type <= i_req_type;
            r_char     <= i_char_value;
            r_pos      <= i_position;
        end
        if (w_exec) begin
            r_out_status <= w_status;
            r_out_read   <= w_read_value;
            r_out_count  <= CNT_OUT_W'(w_n_count);
            r_out_empty  <= (w_n_count == '0);
            r_out_first  <= (w_n_count == '0) ? '0 : w_nxt[0];
            r_out_last   <= w_last_value;
        end
    end

    assign o_rsp_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_read_value  = r_out_read;
    assign o_item_count  = r_out_count;
    assign o_list_empty  = r_out_empty;
    assign o_first_value = r_out_first;
    assign o_last_value  = r_out_last;

    // The count never passes the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(LIST_CAPACITY))
        else $error("item count exceeds capacity");

    // An executed request always lands in the output register.
    a_exec_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_exec |=> r_out_valid)
        else $error("executed request produced no result");

    // A waiting request is never dropped before it executes.
    a_pend_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend && !w_exec) |=> r_pend)
        else $error("pending request lost");

    // At most one cell is the slot of an insert or replace.
    a_one_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_exec |-> $onehot0(w_eq & {LIST_CAPACITY{w_ins | w_rep}}))
        else $error("more than one cell loads the new character");

endmodule

// File: src/icl_cell.sv
// One storage cell of the list: holds one entry and trades it with its neighbors.
// Depends on icl_pkg.
module icl_cell (
    input  logic                      i_clk,
    input  icl_pkg::t_cell_ctl        i_ctl,
    input  logic [icl_pkg::CHAR_W-1:0] i_new_value,
    input  logic [icl_pkg::CHAR_W-1:0] i_left_value,
    input  logic [icl_pkg::CHAR_W-1:0] i_right_value,
    output logic [icl_pkg::CHAR_W-1:0] o_value,
    output logic [icl_pkg::CHAR_W-1:0] o_next_value,
    output logic                      o_greater
);
    import icl_pkg::*;

    logic [CHAR_W-1:0] r_value;
    logic [CHAR_W-1:0] n_value;

    always_comb begin
        priority if (i_ctl.load) begin
            n_value = i_new_value;
        end else if (i_ctl.from_left) begin
            n_value = i_left_value;
        end else if (i_ctl.from_right) begin
            n_value = i_right_value;
        end else begin
            n_value = r_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value      = r_value;
    assign o_next_value = n_value;
    // Signed compare used to find the sorted insertion point.
    assign o_greater    = $signed(r_value) > $signed(i_new_value);

endmodule

// File: tb/indexed_char_list_engine_core_tb.sv
// Self-checking testbench for indexed_char_list_engine_core: random and directed list requests
// against a queue-based shadow of the list. Depends on icl_pkg and the core RTL only.
`timescale 1ns / 100ps

module indexed_char_list_engine_core_tb;
    import icl_pkg::*;

    typedef logic signed [CHAR_W-1:0] t_char;

    // Request codes above REQ_CLEAR are unused; the block must treat them as no-ops.
    localparam logic [REQ_W-1:0] REQ_SPARE_LO = 4'd10;
    localparam logic [REQ_W-1:0] REQ_SPARE_HI = 4'd15;

    // Each stretch of random stimulus leans toward one kind of traffic.
    typedef enum int {
        BURST_FILL,
        BURST_DRAIN,
        BURST_SORTED,
        BURST_MIXED
    } t_burst_mode;

    // One response as seen on the output ports.
    typedef struct {
        logic [STAT_W-1:0]    status;
        t_char                read_value;
        logic [CNT_OUT_W-1:0] item_count;
        logic                 list_empty;
        t_char                first_value;
        t_char                last_value;
    } t_list_rsp;

    // The scoreboard keeps its own copy of the list as a queue. Each accepted request is
    // applied to that copy right away and the response it must produce is queued; responses
    // come back in request order, so each one is checked against the oldest queued entry.
    class t_char_list_board;
        t_char       shadow_list[$];
        t_list_rsp   awaited_rsps[$];
        int unsigned fault_count;

        function int unsigned depth();
            return shadow_list.size();
        endfunction

        function void note_request(logic [REQ_W-1:0] req, t_char ch, logic [POS_W-1:0] pos);
            t_status   st;
            t_list_rsp exp_rsp;
            bit        full;
            int        k;
            st                 = ST_OK;
            exp_rsp.read_value = '0;
            full               = shadow_list.size() >= LIST_CAPACITY;
            k                  = 0;
            // Adds check fullness before the position; removals check emptiness first.
            case (req)
                REQ_PUSH_BACK: begin
                    if (full) st = ST_FULL;
                    else shadow_list.push_back(ch);
                end
                REQ_PUSH_FRONT: begin
                    if (full) st = ST_FULL;
                    else shadow_list.push_front(ch);
                end
                REQ_INSERT_AT: begin
                    if (full) st = ST_FULL;
                    else if (int'(pos) > shadow_list.size()) st = ST_RANGE;
                    else shadow_list.insert(pos, ch);
                end
                REQ_INSERT_SORTED: begin
                    // New entry lands before the first strictly greater entry (signed).
                    if (full) begin
                        st = ST_FULL;
                    end else begin
                        while (k < shadow_list.size() && ch >= shadow_list[k]) k++;
                        shadow_list.insert(k, ch);
                    end
                end
                REQ_POP_FRONT: begin
                    if (shadow_list.size() == 0) st = ST_EMPTY;
                    else void'(shadow_list.pop_front());
                end
                REQ_POP_BACK: begin
                    if (shadow_list.size() == 0) st = ST_EMPTY;
                    else void'(shadow_list.pop_back());
                end
                REQ_REMOVE_AT, REQ_REPLACE, REQ_READ: begin
                    if (shadow_list.size() == 0) st = ST_EMPTY;
                    else if (int'(pos) >= shadow_list.size()) st = ST_RANGE;
                    else if (req == REQ_REMOVE_AT) shadow_list.delete(pos);
                    else if (req == REQ_REPLACE) shadow_list[pos] = ch;
                    else exp_rsp.read_value = shadow_list[pos];
                end
                REQ_CLEAR: begin
                    shadow_list.delete();
                end
                default: begin
                end
            endcase
            exp_rsp.status      = st;
            exp_rsp.item_count  = CNT_OUT_W'(shadow_list.size());
            exp_rsp.list_empty  = (shadow_list.size() == 0);
            exp_rsp.first_value = (shadow_list.size() == 0) ? t_char'(0) : shadow_list[0];
            exp_rsp.last_value  = (shadow_list.size() == 0) ? t_char'(0) : shadow_list[$];
            awaited_rsps.push_back(exp_rsp);
        endfunction

        function void flag(string field, logic signed [15:0] exp_v, logic signed [15:0] got_v);
            fault_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_v, got_v);
        endfunction

        function void check_response(t_list_rsp got);
            t_list_rsp exp_rsp;
            if (awaited_rsps.size() == 0) begin
                fault_count++;
                $display("%0t: response with no request outstanding, expected none, got status %0d",
                         $time, got.status);
                return;
            end
            exp_rsp = awaited_rsps.pop_front();
            if (got.status !== exp_rsp.status)
                flag("status", exp_rsp.status, got.status);
            if (got.read_value !== exp_rsp.read_value)
                flag("read_value", exp_rsp.read_value, got.read_value);
            if (got.item_count !== exp_rsp.item_count)
                flag("item_count", exp_rsp.item_count, got.item_count);
            if (got.list_empty !== exp_rsp.list_empty)
                flag("list_empty", exp_rsp.list_empty, got.list_empty);
            if (got.first_value !== exp_rsp.first_value)
                flag("first_value", exp_rsp.first_value, got.first_value);
            if (got.last_value !== exp_rsp.last_value)
                flag("last_value", exp_rsp.last_value, got.last_value);
        endfunction
    endclass

    // All inputs start at known values; reset is held low from time zero.
    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 i_req_valid  = 1'b0;
    logic [REQ_W-1:0]     i_req_type   = '0;
    t_char                i_char_value = '0;
    logic [POS_W-1:0]     i_position   = '0;
    logic                 i_rsp_ready  = 1'b0;
    logic                 o_req_ready;
    logic                 o_rsp_valid;
    logic [STAT_W-1:0]    o_status;
    t_char                o_read_value;
    logic [CNT_OUT_W-1:0] o_item_count;
    logic                 o_list_empty;
    t_char                o_first_value;
    t_char                o_last_value;

    t_char_list_board board = new();

    indexed_char_list_engine_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_req_valid),
        .o_req_ready   (o_req_ready),
        .i_req_type    (i_req_type),
        .i_char_value  (i_char_value),
        .i_position    (i_position),
        .o_rsp_valid   (o_rsp_valid),
        .i_rsp_ready   (i_rsp_ready),
        .o_status      (o_status),
        .o_read_value  (o_read_value),
        .o_item_count  (o_item_count),
        .o_list_empty  (o_list_empty),
        .o_first_value (o_first_value),
        .o_last_value  (o_last_value)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Presents one request and returns at the edge where it is accepted. It must be called
    // at a rising edge. With no gap, valid simply stays high and only the payload changes,
    // so valid never sees two nonblocking writes in one time step.
    task automatic send_request(input logic [REQ_W-1:0] req, input t_char ch,
                                input logic [POS_W-1:0] pos);
        int gap;
        gap = $urandom_range(0, 10);
        if (gap > 0) begin
            i_req_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_req_valid  <= 1'b1;
        i_req_type   <= req;
        i_char_value <= ch;
        i_position   <= pos;
        // Outputs are read in the active region, so they still hold their pre-edge values.
        do @(posedge i_clk); while (o_req_ready !== 1'b1);
        board.note_request(req, ch, pos);
    endtask

    // A fifth of the characters come from a tiny set so that equal entries and the
    // signed extremes turn up often, which matters most for sorted inserts.
    function automatic t_char pick_char();
        t_char picks[5];
        picks = '{-8'sd128, -8'sd1, 8'sd0, 8'sd1, 8'sd127};
        if ($urandom_range(0, 4) == 0) return picks[$urandom_range(0, 4)];
        return t_char'($urandom_range(0, 255));
    endfunction

    // Positions are mostly within or just past the list so that shifts and range errors
    // are both frequent; a tenth span the whole 7-bit field.
    function automatic logic [POS_W-1:0] pick_position();
        int unsigned n;
        int unsigned roll;
        int unsigned p;
        n    = board.depth();
        roll = $urandom_range(0, 99);
        if (roll < 80) p = $urandom_range(0, n);
        else if (roll < 90) p = n + $urandom_range(0, 2);
        else p = $urandom_range(0, 127);
        return POS_W'(p);
    endfunction

    task automatic random_request(input t_burst_mode mode, output bit counted);
        int unsigned      roll;
        logic [REQ_W-1:0] req;
        roll = $urandom_range(0, 99);
        case (mode)
            BURST_FILL: begin
                if (roll < 85) req = REQ_W'($urandom_range(REQ_PUSH_BACK, REQ_INSERT_SORTED));
                else req = REQ_W'($urandom_range(REQ_POP_FRONT, REQ_CLEAR));
            end
            BURST_DRAIN: begin
                if (roll < 85) req = REQ_W'($urandom_range(REQ_POP_FRONT, REQ_REMOVE_AT));
                else req = REQ_W'($urandom_range(REQ_PUSH_BACK, REQ_READ));
            end
            BURST_SORTED: begin
                // Only requests that keep the list in order, so sorted inserts stay meaningful.
                if (roll < 70) req = REQ_INSERT_SORTED;
                else if (roll < 80) req = REQ_READ;
                else req = REQ_W'($urandom_range(REQ_POP_FRONT, REQ_REMOVE_AT));
            end
            default: begin
                if (roll < 5) req = REQ_W'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
                else req = REQ_W'($urandom_range(REQ_PUSH_BACK, REQ_CLEAR));
            end
        endcase
        send_request(req, pick_char(), pick_position());
        counted = (req <= REQ_CLEAR);
    endtask

    // Stimulus: reset, a directed pass over the special cases, then random bursts.
    initial begin
        int          sent;
        int          burst_len;
        bit          counted;
        int unsigned roll;
        t_burst_mode mode;
        sent = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Everything that must bounce off an empty list.
        send_request(REQ_POP_FRONT, 8'sd0, 7'd0);
        send_request(REQ_POP_BACK, 8'sd0, 7'd0);
        send_request(REQ_REMOVE_AT, 8'sd0, 7'd0);
        send_request(REQ_REPLACE, 8'sd5, 7'd0);
        send_request(REQ_READ, 8'sd0, 7'd127);
        // Insert past the end of an empty list is a range error.
        send_request(REQ_INSERT_AT, 8'sd9, 7'd1);
        // Build -128, -1, 127, 0 using each positional add.
        send_request(REQ_PUSH_BACK, 8'sd127, 7'd0);
        send_request(REQ_PUSH_FRONT, -8'sd128, 7'd0);
        send_request(REQ_INSERT_AT, 8'sd0, 7'd2);
        send_request(REQ_INSERT_AT, -8'sd1, 7'd1);
        send_request(REQ_READ, 8'sd0, 7'd1);
        send_request(REQ_READ, 8'sd0, 7'd4);
        send_request(REQ_REPLACE, 8'sd85, 7'd3);
        send_request(REQ_REMOVE_AT, 8'sd0, 7'd0);
        send_request(REQ_REMOVE_AT, 8'sd0, 7'd100);
        send_request(REQ_SPARE_LO, -8'sd1, 7'd127);
        send_request(REQ_SPARE_HI, 8'sd0, 7'd0);
        send_request(REQ_CLEAR, 8'sd0, 7'd0);
        // Sorted inserts, including an equal value that must land after its twin.
        send_request(REQ_INSERT_SORTED, 8'sd5, 7'd0);
        send_request(REQ_INSERT_SORTED, -8'sd3, 7'd0);
        send_request(REQ_INSERT_SORTED, 8'sd5, 7'd0);
        send_request(REQ_INSERT_SORTED, 8'sd127, 7'd0);
        send_request(REQ_INSERT_SORTED, -8'sd128, 7'd0);
        send_request(REQ_POP_FRONT, 8'sd0, 7'd0);
        send_request(REQ_POP_BACK, 8'sd0, 7'd0);

        // The first burst leans toward adds, to drive the list toward capacity and against it.
        mode      = BURST_FILL;
        burst_len = 110;
        while (sent < 2000) begin
            if (mode == BURST_SORTED) begin
                send_request(REQ_CLEAR, 8'sd0, 7'd0);
                sent++;
            end
            for (int n = 0; n < burst_len; n++) begin
                random_request(mode, counted);
                if (counted) sent++;
            end
            roll = $urandom_range(0, 99);
            if (roll < 30) mode = BURST_FILL;
            else if (roll < 50) mode = BURST_DRAIN;
            else if (roll < 65) mode = BURST_SORTED;
            else mode = BURST_MIXED;
            burst_len = $urandom_range(20, 120);
        end
        i_req_valid <= 1'b0;

        // Drain the outstanding responses, then keep the clock running for anything stray.
        while (board.awaited_rsps.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (board.fault_count == 0 && board.awaited_rsps.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Response side: holds ready low for a random gap, possibly none, before each response and
    // checks every response at the edge that accepts it.
    initial begin
        int        gap;
        t_list_rsp got;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            gap = $urandom_range(0, 10);
            if (gap > 0) begin
                i_rsp_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_rsp_ready <= 1'b1;
            do @(posedge i_clk); while (o_rsp_valid !== 1'b1);
            got.status      = o_status;
            got.read_value  = o_read_value;
            got.item_count  = o_item_count;
            got.list_empty  = o_list_empty;
            got.first_value = o_first_value;
            got.last_value  = o_last_value;
            board.check_response(got);
        end
    end

    // A hung handshake ends the run here; a correct run needs well under a tenth of this.
    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: files.f
src/icl_pkg.sv
src/icl_cell.sv
src/indexed_char_list_engine_core.sv
tb/indexed_char_list_engine_core_tb.sv
